[rtl/crc_checked_word_deframer_core_assert.svh]
// assertion macros for the word deframer core
`ifndef CRC_CHECKED_WORD_DEFRAMER_CORE_ASSERT_SVH
`define CRC_CHECKED_WORD_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define CWD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, off during reset
`define CWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[rtl/crcwd_pkg.sv]
// shared types, constants and crc function for the word deframer
package crcwd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned INDEX_W = 4;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned WPV_W   = 2;
	localparam int unsigned CFG_W   = 5;

	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;

	localparam logic [1:0] WPV_ONE   = 2'd1;
	localparam logic [1:0] WPV_RESET = 2'd2;
	localparam logic [4:0] VPF_RESET = 5'd10;

	// configuration register indexes
	localparam logic REG_WORDS_PER_VALUE  = 1'b0;
	localparam logic REG_VALUES_PER_FRAME = 1'b1;

	typedef enum logic [1:0] {
		PH_HIGH = 2'd0,
		PH_LOW  = 2'd1,
		PH_CRC  = 2'd2
	} phase_t;

	// msb-first crc-8 over one byte, no reflection
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

[rtl/crc_checked_word_deframer_core.sv]
// Word deframer for sensor replies made of 16-bit big-endian words, each followed by a
// crc-8 byte (poly 0x31, init 0xff). One reply byte is taken per request; a byte with
// tuser set starts a new frame. A value is one or two words (words_per_value), and a
// frame holds values_per_frame values (clamped to 1..MAX_VALUES). Each completed value
// leaves as one output request: tdata = value (zero on crc failure) and its index,
// tuser = crc ok, tlast = last value of the frame. After the last value, bytes are
// dropped until the next frame start. The core takes one byte per clock cycle when the
// output is not stalled; a result is offered from the output register after its crc byte
// has passed through the input register, since the byte is worked on straight out of the
// input register and the result is held in the output register. While a result waits,
// one more byte can sit in the input register before the input stalls.
// Configuration writes complete at once and must be made while no byte is in flight.
module crc_checked_word_deframer_core #(
	parameter int unsigned MAX_VALUES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] frame_start
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] value, [35:32] value_index, [39:36] zero
	output logic        m_tuser,   // [0] crc_ok
	output logic        m_tlast,   // frame_last
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [crcwd_pkg::CFG_W-1:0] cfg_data
);

	// configuration
	logic [crcwd_pkg::WPV_W-1:0]   words_per_value_q;
	logic [crcwd_pkg::COUNT_W-1:0] values_per_frame_q;

	// input register
	logic                          valid_s1;
	logic [crcwd_pkg::BYTE_W-1:0]  byte_s1;
	logic                          start_s1;

	// frame state
	crcwd_pkg::phase_t             phase_q, phase_eff, phase_next;
	logic                          word_q;
	logic [crcwd_pkg::COUNT_W-1:0] count_q;
	logic [crcwd_pkg::VALUE_W-1:0] acc_q;
	logic [7:0]                    crc_q;
	logic                          err_q;
	logic                          done_q;

	// next-state values
	logic                          active;
	logic                          word_eff, word_next;
	logic [crcwd_pkg::COUNT_W-1:0] count_eff, count_next;
	logic [crcwd_pkg::VALUE_W-1:0] acc_eff, acc_next;
	logic [7:0]                    crc_eff, crc_next;
	logic                          err_eff, err_next, err_word;
	logic                          done_next;
	logic                          emit;
	logic                          last;
	logic [crcwd_pkg::COUNT_W-1:0] nvals;

	// output register
	logic                          out_valid_q;
	logic [crcwd_pkg::VALUE_W-1:0] out_value_q;
	logic                          out_ok_q;
	logic [crcwd_pkg::INDEX_W-1:0] out_index_q;
	logic                          out_last_q;

	logic                          advance;
	logic                          step;

	assign advance   = !out_valid_q || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign step      = valid_s1 && advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_per_value_q  <= crcwd_pkg::WPV_RESET;
			values_per_frame_q <= crcwd_pkg::VPF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				crcwd_pkg::REG_WORDS_PER_VALUE:  words_per_value_q  <= cfg_data[1:0];
				crcwd_pkg::REG_VALUES_PER_FRAME: values_per_frame_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	// frame start clears the frame before the byte is used
	always_comb begin
		active    = start_s1 || !done_q;
		phase_eff = start_s1 ? crcwd_pkg::PH_HIGH : phase_q;
		word_eff  = start_s1 ? 1'b0 : word_q;
		count_eff = start_s1 ? '0 : count_q;
		acc_eff   = start_s1 ? '0 : acc_q;
		crc_eff   = start_s1 ? crcwd_pkg::CRC_INIT : crc_q;
		err_eff   = start_s1 ? 1'b0 : err_q;
	end

	// byte phase sequencing
	always_comb begin
		phase_next = phase_q;
		if (active) begin
			unique case (phase_eff)
				crcwd_pkg::PH_LOW: phase_next = crcwd_pkg::PH_CRC;
				crcwd_pkg::PH_CRC: phase_next = crcwd_pkg::PH_HIGH;
				default:           phase_next = crcwd_pkg::PH_LOW;
			endcase
		end
	end

	assign nvals = (values_per_frame_q == '0) ? crcwd_pkg::COUNT_W'(1) :
		(values_per_frame_q > crcwd_pkg::COUNT_W'(MAX_VALUES)) ?
		crcwd_pkg::COUNT_W'(MAX_VALUES) : values_per_frame_q;
	assign last     = ({1'b0, count_eff} + 6'd1) >= {1'b0, nvals};
	assign err_word = crc_eff != byte_s1;

	// datapath and result decision
	always_comb begin
		word_next  = word_eff;
		count_next = count_eff;
		acc_next   = acc_eff;
		crc_next   = crc_eff;
		err_next   = err_eff;
		done_next  = start_s1 ? 1'b0 : done_q;
		emit       = 1'b0;
		if (active) begin
			unique case (phase_eff)
				crcwd_pkg::PH_CRC: begin
					crc_next = crcwd_pkg::CRC_INIT;
					if (words_per_value_q != crcwd_pkg::WPV_ONE && !word_eff) begin
						word_next = 1'b1;
						err_next  = err_eff | err_word;
					end else begin
						emit       = 1'b1;
						word_next  = 1'b0;
						count_next = count_eff + crcwd_pkg::COUNT_W'(1);
						acc_next   = '0;
						err_next   = 1'b0;
						done_next  = last;
					end
				end
				default: begin
					crc_next = crcwd_pkg::crc8_byte(crc_eff, byte_s1);
					acc_next = {acc_eff[crcwd_pkg::VALUE_W-crcwd_pkg::BYTE_W-1:0], byte_s1};
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= crcwd_pkg::PH_HIGH;
			word_q  <= 1'b0;
			count_q <= '0;
			acc_q   <= '0;
			crc_q   <= crcwd_pkg::CRC_INIT;
			err_q   <= 1'b0;
			done_q  <= 1'b1;
		end else if (step) begin
			phase_q <= phase_next;
			word_q  <= word_next;
			count_q <= count_next;
			acc_q   <= acc_next;
			crc_q   <= crc_next;
			err_q   <= err_next;
			done_q  <= done_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_value_q <= (err_eff || err_word) ? '0 : acc_eff;
			out_ok_q    <= !(err_eff || err_word);
			out_index_q <= count_eff[crcwd_pkg::INDEX_W-1:0];
			out_last_q  <= last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_index_q, out_value_q};
	assign m_tuser  = out_ok_q;
	assign m_tlast  = out_last_q;

`include "crc_checked_word_deframer_core_assert.svh"

	// a failed value never carries data
	`CWD_ASSERT_IMPL(a_fail_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata[31:0] == 32'd0)
	// an accepted byte lands in the input register
	`CWD_ASSERT_NEXT(a_in_capture, clk, arst_n, s_tvalid && s_tready, valid_s1)
	// a stalled byte is not consumed
	`CWD_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !advance, valid_s1)

endmodule

[tb/tb_crc_checked_word_deframer_core.sv]
// testbench for the crc checked word deframer core: directed table and random frames
`timescale 1ns / 1ps

module tb_crc_checked_word_deframer_core;

	localparam int unsigned MAX_VALUES = 16;
	localparam int RANDOM_ITEMS = 1750;
	localparam int DRAIN_CYCLES = 8;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 3000;
	localparam int MAX_REPORTS = 10;
	localparam int FIXED_SETTINGS = 7;
	localparam int DIR_N = 24;

	typedef struct packed {
		logic [31:0] value;
		logic        ok;
		logic [3:0]  idx;
		logic        last;
	} value_rec_t;

	typedef struct packed {
		logic [7:0] b;
		logic       st;
		logic       typed;
		value_rec_t want;
	} dir_row_t;

	// known word 0xbeef carries crc 0x92
	localparam dir_row_t DIR_ROWS [0:DIR_N-1] = '{
		'{8'h55, 1'b0, 1'b0, '0},
		'{8'hBE, 1'b1, 1'b0, '0},
		'{8'hEF, 1'b0, 1'b0, '0},
		'{8'h92, 1'b0, 1'b0, '0},
		'{8'hBE, 1'b0, 1'b0, '0},
		'{8'hEF, 1'b0, 1'b0, '0},
		'{8'h92, 1'b0, 1'b1, '{32'hBEEFBEEF, 1'b1, 4'd0, 1'b0}},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hBE, 1'b0, 1'b0, '0},
		'{8'hEF, 1'b0, 1'b0, '0},
		'{8'h93, 1'b0, 1'b0, '0},
		'{8'hBE, 1'b0, 1'b0, '0},
		'{8'hEF, 1'b0, 1'b0, '0},
		'{8'h92, 1'b0, 1'b1, '{32'h0, 1'b0, 4'd2, 1'b0}},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b1, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0}
	};

	localparam logic [1:0] FIX_WPV [0:FIXED_SETTINGS-1] = '{
		2'd1, 2'd0, 2'd3, 2'd2, 2'd1, 2'd2, 2'd1
	};
	localparam logic [4:0] FIX_VPF [0:FIXED_SETTINGS-1] = '{
		5'd1, 5'd0, 5'd17, 5'd16, 5'd31, 5'd1, 5'd16
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [4:0]  cfg_data;

	crc_checked_word_deframer_core #(
		.MAX_VALUES(MAX_VALUES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// deframer state as predicted
	crcwd_pkg::phase_t ph = crcwd_pkg::PH_HIGH;
	logic        wsel = 1'b0;
	logic [4:0]  vcount = '0;
	logic [31:0] acc = '0;
	logic [7:0]  crc = crcwd_pkg::CRC_INIT;
	logic        err = 1'b0;
	logic        fr_done = 1'b1;
	logic [1:0]  cfg_wpv = crcwd_pkg::WPV_RESET;
	logic [4:0]  cfg_vpf = crcwd_pkg::VPF_RESET;
	int          taken_bytes = 0;

	value_rec_t  pending_values [$];
	int          mismatch_count = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	bit          pressure_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] crc8_next(input logic [7:0] c_in, input logic [7:0] b);
		logic [7:0] c;
		logic       fb;
		c = c_in;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ b[i];
			c = {c[6:0], 1'b0} ^ (fb ? crcwd_pkg::CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	function automatic int frame_values();
		if (cfg_vpf == 5'd0) begin
			return 1;
		end
		if (cfg_vpf > MAX_VALUES) begin
			return MAX_VALUES;
		end
		return int'(cfg_vpf);
	endfunction

	// advances the predicted state by one byte, returns 1 when a value completes
	function automatic bit deframe_step(input logic [7:0] b, input logic st,
		output value_rec_t rec);
		bit last;
		rec = '0;
		if (st) begin
			ph = crcwd_pkg::PH_HIGH;
			wsel = 1'b0;
			vcount = '0;
			acc = '0;
			crc = crcwd_pkg::CRC_INIT;
			err = 1'b0;
			fr_done = 1'b0;
		end else if (fr_done) begin
			return 1'b0;
		end
		taken_bytes++;
		if (ph != crcwd_pkg::PH_CRC) begin
			crc = crc8_next(crc, b);
			acc = {acc[23:0], b};
			ph = (ph == crcwd_pkg::PH_LOW) ? crcwd_pkg::PH_CRC : crcwd_pkg::PH_LOW;
			return 1'b0;
		end
		if (crc != b) begin
			err = 1'b1;
		end
		crc = crcwd_pkg::CRC_INIT;
		ph = crcwd_pkg::PH_HIGH;
		// two words unless exactly one is configured
		if (cfg_wpv != crcwd_pkg::WPV_ONE && !wsel) begin
			wsel = 1'b1;
			return 1'b0;
		end
		last = (int'(vcount) + 1 >= frame_values());
		rec.value = err ? 32'h0 : acc;
		rec.ok = !err;
		rec.idx = vcount[3:0];
		rec.last = last;
		vcount = vcount + 5'd1;
		acc = '0;
		err = 1'b0;
		wsel = 1'b0;
		if (last) begin
			fr_done = 1'b1;
		end
		return 1'b1;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic st, input logic typed,
		input value_rec_t want);
		value_rec_t rec;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= st;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		if (deframe_step(b, st, rec)) begin
			pending_values.push_back(typed ? want : rec);
		end
	endtask

	// stop sending, let every expected value arrive, then let the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_values.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic [4:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		if (idx == crcwd_pkg::REG_WORDS_PER_VALUE) begin
			cfg_wpv = data[1:0];
		end else begin
			cfg_vpf = data;
		end
		@(posedge clk);
	endtask

	function automatic logic [7:0] random_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// one reply frame at the current setting, sometimes with bad crcs or cut short
	task automatic send_frame();
		int         words;
		int         total;
		int         cut;
		int         sent;
		logic [7:0] word_bytes [0:2];
		words = (cfg_wpv == crcwd_pkg::WPV_ONE) ? 1 : 2;
		total = frame_values() * words * 3;
		cut = ($urandom_range(99) < 10) ? $urandom_range(total - 1, 1) : total;
		sent = 0;
		for (int w = 0; w < total / 3; w++) begin
			word_bytes[0] = random_byte();
			word_bytes[1] = random_byte();
			word_bytes[2] = crc8_next(crc8_next(crcwd_pkg::CRC_INIT, word_bytes[0]),
				word_bytes[1]);
			if ($urandom_range(99) < 8) begin
				word_bytes[2] ^= 8'($urandom_range(255, 1));
			end
			for (int k = 0; k < 3; k++) begin
				if (sent < cut) begin
					send_byte(word_bytes[k], sent == 0, 1'b0, '0);
				end
				sent++;
			end
		end
		// trailing noise, dropped after a complete frame
		if ($urandom_range(99) < 30) begin
			repeat ($urandom_range(4, 1)) begin
				send_byte(random_byte(), 1'b0, 1'b0, '0);
			end
		end
	endtask

	task automatic report_mismatch(input value_rec_t want, input value_rec_t got,
		input bit unexpected);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			if (unexpected) begin
				$display("%0t: unexpected result value=%h ok=%b idx=%0d last=%b",
					$realtime, got.value, got.ok, got.idx, got.last);
			end else begin
				$display("%0t: mismatch exp value=%h ok=%b idx=%0d last=%b",
					$realtime, want.value, want.ok, want.idx, want.last,
					" / got value=%h ok=%b idx=%0d last=%b",
					got.value, got.ok, got.idx, got.last);
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin
		value_rec_t got;
		value_rec_t want;
		if (m_tvalid && m_tready) begin
			got.value = m_tdata[31:0];
			got.ok = m_tuser;
			got.idx = m_tdata[35:32];
			got.last = m_tlast;
			if (pending_values.size() == 0) begin
				report_mismatch('0, got, 1'b1);
			end else begin
				want = pending_values.pop_front();
				if (got !== want) begin
					report_mismatch(want, got, 1'b0);
				end
			end
		end
	end

	// result side ready, with one long hold-off while bytes keep coming
	initial begin
		int hold_left;
		bit pressure_done;
		hold_left = 0;
		pressure_done = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (pressure_req && !pressure_done) begin
				pressure_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles with no request accepted anywhere
	initial begin
		int stall_run;
		stall_run = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
				stall_run = 0;
			end else begin
				stall_run++;
			end
			if (stall_run >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int         start_taken;
		int         progress;
		int         setting;
		logic [1:0] wpv;
		logic [4:0] vpf;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= crcwd_pkg::REG_WORDS_PER_VALUE;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset settings
		send_idle_pct <= 28;
		recv_idle_pct <= 67;
		for (int r = 0; r < DIR_N; r++) begin
			send_byte(DIR_ROWS[r].b, DIR_ROWS[r].st, DIR_ROWS[r].typed, DIR_ROWS[r].want);
		end

		start_taken = taken_bytes;
		setting = 0;
		while (taken_bytes - start_taken < RANDOM_ITEMS) begin
			settle();
			if (setting < FIXED_SETTINGS) begin
				wpv = FIX_WPV[setting];
				vpf = FIX_VPF[setting];
			end else begin
				wpv = 2'($urandom_range(3));
				vpf = ($urandom_range(99) < 60) ? 5'($urandom_range(4, 1))
					: 5'($urandom_range(31));
			end
			write_cfg(crcwd_pkg::REG_WORDS_PER_VALUE, {3'b000, wpv});
			write_cfg(crcwd_pkg::REG_VALUES_PER_FRAME, vpf);
			setting++;
			progress = taken_bytes - start_taken;
			if (progress < RANDOM_ITEMS / 3) begin
				send_idle_pct <= 28;
				recv_idle_pct <= 67;
			end else if (progress < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct <= 67;
				recv_idle_pct <= 28;
			end else begin
				send_idle_pct <= 0;
				recv_idle_pct <= 0;
				if (!pressure_req) begin
					pressure_req <= 1'b1;
				end
			end
			repeat ($urandom_range(6, 2)) begin
				send_frame();
			end
		end

		s_tvalid <= 1'b0;
		while (pending_values.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_values.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
